/* sv/ilp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ilp_pkg;

    localparam int MAX_LEN_DEF = 255;

    localparam int ACC_W = 32;
    localparam int SCALED_W = ACC_W + 4;

    localparam logic [ACC_W-1:0] ACC_POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [ACC_W-1:0] ACC_NEG_LIMIT = 32'h8000_0000;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_CASE_BIT = 8'h20;

    typedef enum logic [2:0] {
        PH_WS1 = 3'd0,
        PH_WS2 = 3'd1,
        PH_PFX = 3'd2,
        PH_DIG = 3'd3
    } phase_t;

    typedef enum logic [1:0] {
        RAD_DEC = 2'd0,
        RAD_OCT = 2'd1,
        RAD_HEX = 2'd2
    } radix_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        phase_t           phase;
        logic             negative;
        radix_t           radix;
        logic [ACC_W-1:0] acc;
        logic             overflowed;
        logic             emitted;
    } parse_state_t;

    typedef struct packed {
        logic signed [31:0] value;
        status_t            status;
    } parse_result_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        phase:      PH_WS1,
        negative:   1'b0,
        radix:      RAD_DEC,
        acc:        '0,
        overflowed: 1'b0,
        emitted:    1'b0
    };

endpackage

`default_nettype wire

/* sv/integer_literal_parser.sv */
// Integer literal parser.
// Slave stream: one string byte per request in s_tdata, s_tlast on the final
// byte. Master stream: one result per string, sent when parsing stops (first
// byte not accepted, NUL, or the byte with s_tlast). Bytes after a result are
// dropped until s_tlast, which restarts the parse.
// Pipeline: a byte is held in the input register, then its result lands in
// the output register, which drives m_tvalid. Throughput: one byte per
// cycle while the receiver is not stalling, set by the combinational
// multiply-add of the accumulator between the two registers.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parse to leading whitespace with a zero accumulator and position.
// When the receiver stalls with a result pending, the input register still
// takes one byte; further bytes wait on s_tready until m_tready returns.
// end_offset is the position masked to 8 bits; the position saturates at
// MAX_LEN.
`timescale 1ns / 1ps
`default_nettype none

module integer_literal_parser
    import ilp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // [31:0] value, [33:32] status, [41:34] end_offset
);

    localparam int POS_W = $clog2(MAX_LEN + 1);

    logic             in_valid_reg;
    logic [7:0]       in_ch_reg;
    logic             in_last_reg;
    parse_state_t     state_reg;
    parse_state_t     state_next;
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    logic [POS_W-1:0] offset;
    logic             out_valid_reg;
    parse_result_t    out_result_reg;
    logic [7:0]       out_offset_reg;
    logic             emit;
    parse_result_t    result;
    logic             advance;
    logic             process;

    assign advance = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign process = in_valid_reg && advance;

    ilp_step #(
        .MAX_LEN(MAX_LEN),
        .POS_W(POS_W)
    ) u_step (
        .ch(in_ch_reg),
        .last(in_last_reg),
        .state(state_reg),
        .position(position_reg),
        .state_next(state_next),
        .position_next(position_next),
        .offset(offset),
        .emit(emit),
        .result(result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg <= PARSE_STATE_RESET;
            position_reg <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= process && emit;
            end
            if (process) begin
                state_reg <= state_next;
                position_reg <= position_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_ch_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (process && emit) begin
            out_result_reg <= result;
            out_offset_reg <= 8'(offset);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'b0, out_offset_reg, out_result_reg.status, out_result_reg.value};

    a_malformed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_result_reg.status == ST_MALFORMED) |-> (out_result_reg.value == 0))
        else $error("malformed octal result carries a nonzero value");

    a_position_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        position_reg <= POS_W'(MAX_LEN))
        else $error("position beyond MAX_LEN");

    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && state_reg.emitted) |-> !emit)
        else $error("second result for one string");

    a_emitted_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && emit && !in_last_reg) |=> state_reg.emitted)
        else $error("parse not closed after result");

endmodule

`default_nettype wire

/* sv/ilp_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module ilp_step
    import ilp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int POS_W = $clog2(MAX_LEN + 1)
) (
    input  wire logic [7:0]       ch,
    input  wire logic             last,
    input  wire parse_state_t     state,
    input  wire logic [POS_W-1:0] position,
    output parse_state_t          state_next,
    output logic [POS_W-1:0]      position_next,
    output logic [POS_W-1:0]      offset,
    output logic                  emit,
    output parse_result_t         result
);

    logic [7:0]          lower;
    logic                is_ws;
    logic                is_sign;
    logic                dec_digit;
    logic                hex_letter;
    logic                malformed;
    logic                digit_ok;
    logic [3:0]          dval;
    logic [SCALED_W-1:0] acc_wide;
    logic [SCALED_W-1:0] scaled;
    logic [SCALED_W-1:0] sum;
    logic [ACC_W-1:0]    limit;
    logic                over;
    logic                consumed;
    logic                bad_octal;
    parse_state_t        upd;
    logic [ACC_W-1:0]    magnitude;

    assign lower = ch | CH_CASE_BIT;
    assign is_ws = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    assign is_sign = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign dec_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign hex_letter = (state.radix == RAD_HEX) && (lower >= CH_LOW_A) && (lower <= CH_LOW_F);
    assign malformed = (state.radix == RAD_OCT) && (ch > CH_SEVEN) && (ch <= CH_NINE);
    assign digit_ok = (dec_digit && !malformed) || hex_letter;
    assign dval = dec_digit ? 4'(ch - CH_ZERO) : 4'(lower - CH_LOW_A + 8'd10);

    assign acc_wide = SCALED_W'(state.acc);

    always_comb begin
        unique case (state.radix)
            RAD_OCT: scaled = acc_wide << 3;
            RAD_HEX: scaled = acc_wide << 4;
            default: scaled = (acc_wide << 3) + (acc_wide << 1);
        endcase
    end

    assign sum = scaled + SCALED_W'(dval);
    assign limit = state.negative ? ACC_NEG_LIMIT : ACC_POS_LIMIT;
    assign over = sum > SCALED_W'(limit);

    always_comb begin
        upd = state;
        consumed = 1'b0;
        bad_octal = 1'b0;
        priority if (position >= POS_W'(MAX_LEN)) begin
            consumed = 1'b0;
        end else if ((state.phase == PH_WS1 || state.phase == PH_WS2) && is_ws) begin
            consumed = 1'b1;
        end else if (state.phase == PH_WS1 && is_sign) begin
            consumed = 1'b1;
            upd.negative = (ch == CH_MINUS);
            upd.phase = PH_WS2;
        end else if ((state.phase == PH_WS1 || state.phase == PH_WS2) && ch == CH_ZERO) begin
            consumed = 1'b1;
            upd.radix = RAD_OCT;
            upd.phase = PH_PFX;
        end else if (state.phase == PH_PFX && lower == CH_LOW_X) begin
            consumed = 1'b1;
            upd.radix = RAD_HEX;
            upd.phase = PH_DIG;
        end else if (malformed) begin
            bad_octal = 1'b1;
        end else if (digit_ok) begin
            consumed = 1'b1;
            upd.acc = over ? limit : sum[ACC_W-1:0];
            upd.overflowed = state.overflowed | over;
            upd.phase = PH_DIG;
        end else begin
            consumed = 1'b0;
        end
    end

    assign emit = !state.emitted && (!consumed || last);
    assign magnitude = upd.negative ? (ACC_W'(0) - upd.acc) : upd.acc;
    assign offset = consumed ? position + POS_W'(1) : position;

    always_comb begin
        if (bad_octal) begin
            result.value = '0;
            result.status = ST_MALFORMED;
        end else begin
            result.value = $signed(magnitude);
            result.status = upd.overflowed ? ST_OVERFLOW : ST_OK;
        end
    end

    always_comb begin
        if (last) begin
            state_next = PARSE_STATE_RESET;
            position_next = '0;
        end else if (state.emitted) begin
            state_next = state;
            position_next = position;
        end else begin
            state_next = upd;
            state_next.emitted = emit;
            position_next = offset;
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ilp_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        status_t     status;
        logic [7:0]  end_off;
    } lit_result_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        lst;
        logic        typed;
        logic [31:0] value;
        status_t     status;
        logic [7:0]  end_off;
    } lit_row_t;

    typedef enum logic [1:0] {
        FATE_TAKEN,
        FATE_REJECT,
        FATE_BAD_OCTAL
    } byte_fate_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    logic        row_typed = 1'b0;
    lit_result_t row_want = '0;

    int send_idle = 21;
    int recv_idle = 48;
    int mismatch_cnt = 0;
    int checked_cnt = 0;
    int byte_cnt = 0;
    int str_cnt = 0;

    lit_result_t want_q [$];
    logic [7:0]  lit_bytes [$];

    // parser state tracked alongside the block
    phase_t      prs_phase;
    logic        prs_neg;
    radix_t      prs_radix;
    logic [32:0] prs_acc;
    logic [7:0]  prs_pos;
    logic        prs_done;
    logic        prs_ovf;

    logic [7:0] ws_bytes [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    string limit_strs [6] = '{"2147483647", "-2147483648", "2147483648",
                              "-2147483649", "0x7FFFFFFF", "-0x80000000"};

    lit_row_t dir_rows [25] = '{
        '{8'h37,    1'b1, 1'b1, 32'd7,          ST_OK,        8'd1},
        '{CH_MINUS, 1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_ZERO,  1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_LOW_X, 1'b1, 1'b1, 32'd0,          ST_OK,        8'd3},
        '{CH_ZERO,  1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_NINE,  1'b0, 1'b1, 32'd0,          ST_MALFORMED, 8'd1},
        '{8'h5A,    1'b1, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{8'h00,    1'b1, 1'b1, 32'd0,          ST_OK,        8'd0},
        '{8'hFF,    1'b1, 1'b1, 32'd0,          ST_OK,        8'd0},
        '{CH_SPACE, 1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_PLUS,  1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_TAB,   1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{8'h35,    1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_LOW_A, 1'b0, 1'b1, 32'd5,          ST_OK,        8'd4},
        '{8'h31,    1'b1, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_NINE,  1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_NINE,  1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_NINE,  1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_NINE,  1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_NINE,  1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_NINE,  1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_NINE,  1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_NINE,  1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_NINE,  1'b0, 1'b0, 32'd0,          ST_OK,        8'd0},
        '{CH_NINE,  1'b1, 1'b1, 32'h7FFF_FFFF,  ST_OVERFLOW,  8'd10}
    };

    integer_literal_parser uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic void clear_parse_state();
        prs_phase = PH_WS1;
        prs_neg   = 1'b0;
        prs_radix = RAD_DEC;
        prs_acc   = '0;
        prs_pos   = '0;
        prs_done  = 1'b0;
        prs_ovf   = 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] ch, input logic lst,
                                      output lit_result_t res);
        byte_fate_t  fate;
        logic [7:0]  lc;
        logic [4:0]  dv;
        logic [39:0] nxt;
        logic [39:0] lim;
        logic [39:0] base;
        logic        take_digit;
        logic        is_digit;
        res = '0;
        if (prs_done) begin
            if (lst) begin
                clear_parse_state();
            end
            return 1'b0;
        end
        fate = FATE_TAKEN;
        take_digit = 1'b0;
        dv = '0;
        lc = ch | CH_CASE_BIT;
        if (int'(prs_pos) >= MAX_LEN_DEF) begin
            fate = FATE_REJECT;
        end else if (prs_phase == PH_WS1 || prs_phase == PH_WS2) begin
            if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
                fate = FATE_TAKEN;
            end else if (prs_phase == PH_WS1 && (ch == CH_MINUS || ch == CH_PLUS)) begin
                prs_neg = (ch == CH_MINUS);
                prs_phase = PH_WS2;
            end else if (ch == CH_ZERO) begin
                prs_radix = RAD_OCT;
                prs_phase = PH_PFX;
            end else begin
                take_digit = 1'b1;
            end
        end else if (prs_phase == PH_PFX && lc == CH_LOW_X) begin
            prs_radix = RAD_HEX;
            prs_phase = PH_DIG;
        end else begin
            take_digit = 1'b1;
        end
        if (take_digit) begin
            is_digit = 1'b1;
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                dv = 5'(ch - CH_ZERO);
            end else if (prs_radix == RAD_HEX && lc >= CH_LOW_A && lc <= CH_LOW_F) begin
                dv = 5'(lc - CH_LOW_A + 8'd10);
            end else begin
                is_digit = 1'b0;
            end
            if (!is_digit) begin
                fate = FATE_REJECT;
            end else if (prs_radix == RAD_OCT && dv > 5'd7) begin
                fate = FATE_BAD_OCTAL;
            end else begin
                lim = prs_neg ? {8'd0, ACC_NEG_LIMIT} : {8'd0, ACC_POS_LIMIT};
                case (prs_radix)
                    RAD_OCT: base = 40'd8;
                    RAD_HEX: base = 40'd16;
                    default: base = 40'd10;
                endcase
                nxt = {7'd0, prs_acc} * base + {35'd0, dv};
                if (nxt > lim) begin
                    nxt = lim;
                    prs_ovf = 1'b1;
                end
                prs_acc = nxt[32:0];
                prs_phase = PH_DIG;
            end
        end
        if (fate == FATE_TAKEN && int'(prs_pos) < MAX_LEN_DEF) begin
            prs_pos = prs_pos + 8'd1;
        end
        if (fate == FATE_TAKEN && !lst) begin
            return 1'b0;
        end
        if (fate == FATE_BAD_OCTAL) begin
            res.value = '0;
            res.status = ST_MALFORMED;
        end else begin
            res.value = prs_neg ? -prs_acc[31:0] : prs_acc[31:0];
            res.status = prs_ovf ? ST_OVERFLOW : ST_OK;
        end
        res.end_off = prs_pos;
        if (lst) begin
            clear_parse_state();
        end else begin
            prs_done = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_ws();
        return ws_bytes[$urandom_range(5)];
    endfunction

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        lit_result_t got;
        lit_result_t want;
        lit_result_t pred;
        bit          has;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.value   = m_tdata[31:0];
                got.status  = status_t'(m_tdata[33:32]);
                got.end_off = m_tdata[41:34];
                if (want_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("unexpected result: value %h status %0d end_offset %0d",
                                 got.value, got.status, got.end_off);
                    end
                end else begin
                    want = want_q.pop_front();
                    checked_cnt++;
                    if (got.value !== want.value || got.status !== want.status ||
                        got.end_off !== want.end_off) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("mismatch: value %h/%h status %0d/%0d end_offset %0d/%0d",
                                     want.value, got.value, want.status, got.status,
                                     want.end_off, got.end_off);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                has = parse_byte(s_tdata, s_tlast, pred);
                if (row_typed) begin
                    want_q.push_back(row_want);
                end else if (has) begin
                    want_q.push_back(pred);
                end
            end
        end
    end

    // call at a falling edge; returns at the falling edge after the request
    task automatic send_byte(input logic [7:0] ch, input logic lst, input logic typed,
                             input lit_result_t want);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= ch;
        s_tlast   <= lst;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge aclk); while (!s_tready);
        byte_cnt++;
        if (lst) begin
            str_cnt++;
        end
        @(negedge aclk);
    endtask

    task automatic send_lit_string();
        for (int i = 0; i < lit_bytes.size(); i++) begin
            send_byte(lit_bytes[i], i == lit_bytes.size() - 1, 1'b0, '0);
        end
    endtask

    task automatic hold_off();
        s_tvalid <= 1'b0;
        while (want_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic build_random_string();
        int         kind;
        int         n;
        int         sgn;
        int         ending;
        int         d;
        string      s;
        logic [7:0] b;
        lit_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 8) begin
            s = limit_strs[$urandom_range(5)];
            for (int i = 0; i < s.len(); i++) begin
                lit_bytes.push_back(s[i]);
            end
        end else if (kind < 80) begin
            repeat ($urandom_range(2)) lit_bytes.push_back(rand_ws());
            sgn = $urandom_range(2);
            if (sgn == 1) begin
                lit_bytes.push_back(CH_PLUS);
            end else if (sgn == 2) begin
                lit_bytes.push_back(CH_MINUS);
            end
            if (sgn != 0 && $urandom_range(5) == 0) begin
                lit_bytes.push_back(rand_ws());
            end
            n = ($urandom_range(3) == 0) ? $urandom_range(12, 7) : $urandom_range(6);
            case ($urandom_range(2))
                0: begin
                    b = 8'(CH_ZERO + 1 + $urandom_range(8));
                    lit_bytes.push_back(b);
                    repeat (n) begin
                        b = 8'(CH_ZERO + $urandom_range(9));
                        lit_bytes.push_back(b);
                    end
                end
                1: begin
                    lit_bytes.push_back(CH_ZERO);
                    repeat (n) begin
                        b = 8'(CH_ZERO + $urandom_range(7));
                        lit_bytes.push_back(b);
                    end
                    if ($urandom_range(5) == 0) begin
                        b = 8'(CH_ZERO + 8 + $urandom_range(1));
                        lit_bytes.insert(lit_bytes.size() - $urandom_range(n), b);
                    end
                end
                default: begin
                    lit_bytes.push_back(CH_ZERO);
                    lit_bytes.push_back($urandom_range(1) ? CH_LOW_X : (CH_LOW_X ^ CH_CASE_BIT));
                    repeat (n) begin
                        d = $urandom_range(15);
                        if (d < 10) begin
                            b = 8'(CH_ZERO + d);
                        end else begin
                            b = 8'(CH_LOW_A + d - 10);
                            if ($urandom_range(1)) begin
                                b = b ^ CH_CASE_BIT;
                            end
                        end
                        lit_bytes.push_back(b);
                    end
                end
            endcase
            ending = $urandom_range(3);
            if (ending >= 1) begin
                b = (ending == 3) ? 8'h00 : 8'($urandom_range(255));
                lit_bytes.push_back(b);
            end
            if (ending >= 2) begin
                repeat ($urandom_range(3)) begin
                    b = 8'($urandom_range(255));
                    lit_bytes.push_back(b);
                end
            end
        end else begin
            repeat ($urandom_range(6, 1)) begin
                b = 8'($urandom_range(255));
                lit_bytes.push_back(b);
            end
        end
    endtask

    initial begin
        lit_result_t want;
        int          rnd_start;
        int          sent;
        bit          drained;
        clear_parse_state();
        drained = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            want.value   = dir_rows[i].value;
            want.status  = dir_rows[i].status;
            want.end_off = dir_rows[i].end_off;
            send_byte(dir_rows[i].ch, dir_rows[i].lst, dir_rows[i].typed, want);
        end
        hold_off();

        rnd_start = byte_cnt;
        sent = 0;
        while (sent < 170) begin
            if (sent >= 112) begin
                send_idle = 0;
                recv_idle = 0;
            end else if (sent >= 56) begin
                if (!drained) begin
                    hold_off();
                    drained = 1'b1;
                end
                send_idle = 48;
                recv_idle = 21;
            end
            build_random_string();
            send_lit_string();
            sent = byte_cnt - rnd_start;
        end

        // run to or past the length limit once
        lit_bytes.delete();
        repeat ($urandom_range(258, 252)) lit_bytes.push_back(rand_ws());
        lit_bytes.push_back(8'h34);
        lit_bytes.push_back(8'h32);
        lit_bytes.push_back(8'h37);
        send_lit_string();

        hold_off();
        repeat (12) @(posedge aclk);
        $display("Covered %0d strings in %0d bytes, %0d results compared.",
                 str_cnt, byte_cnt, checked_cnt);
        $display("Mix: signed dec/oct/hex, saturation, bad octal, NUL, junk, over-long run.");
        if (mismatch_cnt == 0 && want_q.size() == 0) begin
            $display("PASS integer_literal_parser");
        end else begin
            $display("FAIL integer_literal_parser");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL integer_literal_parser");
        $finish;
    end

endmodule

/* files.f */
sv/ilp_pkg.sv
sv/ilp_step.sv
sv/integer_literal_parser.sv
tb/sv/tb_top.sv
